FILE: hw/rtl/cbm_pkg.sv
package cbm_pkg;

  // Store address widths.
  localparam int ROM_AW = 17;
  localparam int RAM_AW = 15;

  // Access modes carried in the mode field.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  // External device codes carried in the external_target field.
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_RIOT = 2'd1;
  localparam logic [1:0] TGT_TIA  = 2'd2;

  // The previous access qualifies a hotspot when its data matches this pattern.
  localparam logic [7:0] QUAL_MASK  = 8'he0;
  localparam logic [7:0] QUAL_VALUE = 8'h60;

  // Where the byte of a result comes from.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_EXT,
    SRC_ROM,
    SRC_RAM
  } src_t;

  // Window offsets and ROM/RAM selects.
  typedef struct packed {
    logic [15:0] low_off;
    logic [15:0] mid_off;
    logic [15:0] high_off;
    logic        low_rom;
    logic        mid_rom;
    logic        high_rom;
  } bank_t;

  // Memory requests issued in the accept cycle.
  typedef struct packed {
    logic              rom_en;
    logic              rom_we;
    logic [ROM_AW-1:0] rom_addr;
    logic              ram_en;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        wdata;
    src_t              src;
    logic [1:0]        target;
  } mem_req_t;

  // Item waiting for its memory data.
  typedef struct packed {
    logic [1:0]  mode;
    logic [12:0] addr;
    logic [7:0]  data;
    src_t        src;
    logic [1:0]  target;
  } stage_t;

  // What a finishing access tells the bank registers.
  typedef struct packed {
    logic        bus;
    logic        low_page;
    logic        top_page;
    logic [12:0] addr;
    logic [7:0]  value;
  } retire_t;

endpackage

FILE: hw/rtl/cbm_access_if.sv
interface cbm_access_if;
  import cbm_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [12:0] bus_address;
  logic [7:0]  data_in;
  logic [16:0] rom_index;

  modport source (output valid, output mode, output bus_address, output data_in,
                  output rom_index, input ready);
  modport sink (input valid, input mode, input bus_address, input data_in,
                input rom_index, output ready);
endinterface

FILE: hw/rtl/cbm_result_if.sv
interface cbm_result_if;
  import cbm_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] external_target;

  modport source (output valid, output read_data, output external_target, input ready);
  modport sink (input valid, input read_data, input external_target, output ready);
endinterface

FILE: hw/rtl/cbm_cfg_if.sv
interface cbm_cfg_if;
  import cbm_pkg::*;

  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cbm_ram.sv
module cbm_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hw/rtl/cbm_decode.sv
module cbm_decode import cbm_pkg::*; (
  input  logic              fire,
  input  logic [1:0]        mode,
  input  logic [12:0]       addr,
  input  logic [7:0]        data,
  input  logic [ROM_AW-1:0] rom_index,
  input  bank_t             bank,
  output mem_req_t          req
);

  logic [ROM_AW-1:0] low_sum;
  logic [ROM_AW-1:0] mid_sum;
  logic [ROM_AW-1:0] high_sum;
  logic              wr;
  mem_req_t          r;

  assign low_sum  = {6'd0, addr[10:0]} + {1'b0, bank.low_off};
  assign mid_sum  = {6'd0, addr[10:0]} + {1'b0, bank.mid_off};
  assign high_sum = {9'd0, addr[7:0]} + {1'b0, bank.high_off};
  assign wr = (mode == MODE_WRITE);

  always_comb begin
    r = '0;
    r.src = SRC_ZERO;
    r.target = TGT_NONE;
    r.wdata = data;
    case (mode)
      MODE_LOAD: begin
        r.rom_en   = 1'b1;
        r.rom_we   = 1'b1;
        r.rom_addr = rom_index;
      end
      MODE_READ, MODE_WRITE: begin
        if (!addr[12]) begin
          if (addr[7]) begin
            r.target = TGT_RIOT;
          end else if (!addr[9]) begin
            r.target = TGT_TIA;
          end
          if (!wr && r.target != TGT_NONE) begin
            r.src = SRC_EXT;
          end
        end else if (!addr[11]) begin
          if (bank.low_rom) begin
            r.rom_en   = !wr;
            r.rom_addr = low_sum;
            r.src      = wr ? SRC_ZERO : SRC_ROM;
          end else begin
            r.ram_en   = 1'b1;
            r.ram_we   = wr;
            r.ram_addr = low_sum[RAM_AW-1:0];
            r.src      = wr ? SRC_ZERO : SRC_RAM;
          end
        end else if (addr[10:9] != 2'b11) begin
          if (bank.mid_rom) begin
            r.rom_en   = !wr;
            r.rom_addr = mid_sum ^ 17'h10000;
            r.src      = wr ? SRC_ZERO : SRC_ROM;
          end else begin
            r.ram_en   = 1'b1;
            r.ram_we   = wr;
            r.ram_addr = mid_sum[RAM_AW-1:0];
            r.src      = wr ? SRC_ZERO : SRC_RAM;
          end
        end else if (!addr[8]) begin
          if (bank.high_rom) begin
            r.rom_en   = !wr;
            r.rom_addr = high_sum ^ 17'h10000;
            r.src      = wr ? SRC_ZERO : SRC_ROM;
          end else begin
            r.ram_en   = 1'b1;
            r.ram_we   = wr;
            r.ram_addr = high_sum[RAM_AW-1:0];
            r.src      = wr ? SRC_ZERO : SRC_RAM;
          end
        end else begin
          // Fixed top page: the last 256 bytes of ROM.
          r.rom_en   = !wr;
          r.rom_addr = {9'h1ff, addr[7:0]};
          r.src      = wr ? SRC_ZERO : SRC_ROM;
        end
      end
      default: begin
        r.rom_en = 1'b0;
      end
    endcase
    req = r;
    req.rom_en = r.rom_en & fire;
    req.ram_en = r.ram_en & fire;
  end

endmodule

FILE: hw/rtl/cbm_bank_regs.sv
module cbm_bank_regs import cbm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pending,
  input  logic    commit,
  input  retire_t ret,
  input  logic    bank_lock,
  output bank_t   fwd
);

  bank_t       bank;
  bank_t       bank_next;
  logic [7:0]  prev_data;
  logic [12:0] prev_addr;
  logic        qual;
  logic [11:0] a;
  logic [7:0]  v;

  assign a = ret.addr[11:0];
  assign v = ret.value;
  assign qual = ((prev_data & QUAL_MASK) == QUAL_VALUE) &&
                (prev_addr[12] || prev_addr < 13'h200);

  always_comb begin
    bank_next = bank;
    if (ret.bus && !bank_lock) begin
      if (ret.low_page) begin
        if (qual) begin
          if ((a & 12'hf00) == 12'hc00) begin
            bank_next.high_rom = 1'b1;
            bank_next.high_off = {a[7:0], 8'h00};
          end else if ((a & 12'hf00) == 12'hd00) begin
            bank_next.high_rom = 1'b0;
            bank_next.high_off = {1'b0, a[6:0], 8'h00};
          end else if ((a & 12'hf40) == 12'he00) begin
            bank_next.low_rom = 1'b1;
            bank_next.low_off = {a[4:0], 11'h000};
          end else if ((a & 12'hf40) == 12'he40) begin
            bank_next.low_rom = 1'b0;
            bank_next.low_off = {1'b0, a[3:0], 11'h000};
          end else if ((a & 12'hf40) == 12'hf00) begin
            bank_next.mid_rom = 1'b1;
            bank_next.mid_off = {a[4:0], 11'h000};
          end else if ((a & 12'hf50) == 12'hf40) begin
            bank_next.mid_rom = 1'b0;
            bank_next.mid_off = {1'b0, a[3:0], 11'h000};
          end else if ((a & 12'hf00) == 12'h400) begin
            bank_next.low_off = bank.low_off ^ 16'h0800;
          end else if ((a & 12'hf00) == 12'h500) begin
            bank_next.low_off = bank.low_off ^ 16'h1000;
          end else if ((a & 12'hf00) == 12'h800) begin
            bank_next.mid_off = bank.mid_off ^ 16'h0800;
          end else if ((a & 12'hf00) == 12'h900) begin
            bank_next.mid_off = bank.mid_off ^ 16'h1000;
          end
        end
        // Zero-page hotspots take the bank from the data byte.
        if ((a & 12'hf75) == 12'h074) begin
          bank_next.high_rom = 1'b1;
          bank_next.high_off = {v, 8'h00};
        end else if ((a & 12'hf75) == 12'h075) begin
          bank_next.high_rom = 1'b0;
          bank_next.high_off = {1'b0, v[6:0], 8'h00};
        end else if ((a & 12'hf7c) == 12'h078) begin
          case (v[7:4])
            4'h0: begin
              bank_next.low_rom = 1'b1;
              bank_next.low_off = {1'b0, v[3:0], 11'h000};
            end
            4'h4: begin
              bank_next.low_rom = 1'b0;
              bank_next.low_off = {1'b0, v[3:0], 11'h000};
            end
            4'h9: begin
              bank_next.mid_rom = 1'b1;
              bank_next.mid_off = {1'b1, v[3:0], 11'h000};
            end
            4'hc: begin
              bank_next.mid_rom = 1'b0;
              bank_next.mid_off = {1'b0, v[3:0], 11'h000};
            end
            default: begin
              bank_next.low_rom = bank.low_rom;
            end
          endcase
        end
      end else if (ret.top_page && qual) begin
        bank_next.high_off = {bank.high_off[15:12], a[3], a[6:4], bank.high_off[7:0]};
      end
    end
  end

  // An access still waiting for its data already decides the banks of the next one.
  assign fwd = pending ? bank_next : bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank.low_off  <= 16'h0000;
      bank.mid_off  <= 16'h0000;
      bank.high_off <= 16'h0000;
      bank.low_rom  <= 1'b1;
      bank.mid_rom  <= 1'b1;
      bank.high_rom <= 1'b1;
      prev_data     <= 8'hff;
      prev_addr     <= 13'h1fff;
    end else if (commit) begin
      bank <= bank_next;
      if (ret.bus) begin
        prev_data <= ret.value;
        prev_addr <= ret.addr;
      end
    end
  end

endmodule

FILE: hw/rtl/cartridge_bank_mapper_unit.sv
// An accepted word waits in the stage register, then moves to the output register.
// Throughput: one word per cycle unless output stalls; ROM and RAM each do one access per cycle.
// A result waits in the output register while the next word is taken in.
// Reset clears the handshake state and the bank lock, maps every window to ROM offset 0,
// and sets the previous data and address to 0xff and 0x1fff; ROM and RAM keep their contents.
module cartridge_bank_mapper_unit import cbm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  cbm_access_if.sink   acc,
  cbm_result_if.source res,
  cbm_cfg_if.sink      cfg
);

  // The pipeline has two steps. In the accept cycle the address of the word is
  // decoded against the current banks and the ROM or RAM access is issued; RAM
  // writes and ROM loads complete right there, so later reads always see them.
  // Once the read data is back, the result byte is chosen, the hotspots are
  // evaluated and the bank registers are updated as the word moves to the output
  // register. Because the waiting word may retarget a window, its new bank state
  // is forwarded to the decode of the word being accepted behind it.

  logic       bank_lock;
  logic       fire;
  logic       s_valid;
  logic       s_adv;
  stage_t     s;
  bank_t      bank_fwd;
  mem_req_t   req;
  retire_t    ret;
  logic [7:0] rom_rdata;
  logic [7:0] ram_rdata;
  logic [7:0] value;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic [1:0] out_target;

  // The waiting word leaves when the output register is empty or being emptied.
  // New words are only taken when the waiting slot frees up, so the memory read
  // data registers hold steady while the output side stalls.
  assign s_adv     = s_valid && (!out_valid || res.ready);
  assign acc.ready = !s_valid || s_adv;
  assign fire      = acc.valid && acc.ready;

  // The configuration channel is always ready; the lock is to be written while idle, which the block does not enforce.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_lock <= 1'b0;
    end else if (cfg.valid) begin
      bank_lock <= cfg.data;
    end
  end

  cbm_decode u_decode (
    .fire      (fire),
    .mode      (acc.mode),
    .addr      (acc.bus_address),
    .data      (acc.data_in),
    .rom_index (acc.rom_index),
    .bank      (bank_fwd),
    .req       (req)
  );

  cbm_ram #(.ADDR_W(ROM_AW), .DATA_W(8)) u_rom (
    .clk   (clk),
    .en    (req.rom_en),
    .we    (req.rom_we),
    .addr  (req.rom_addr),
    .wdata (req.wdata),
    .rdata (rom_rdata)
  );

  cbm_ram #(.ADDR_W(RAM_AW), .DATA_W(8)) u_ram (
    .clk   (clk),
    .en    (req.ram_en),
    .we    (req.ram_we),
    .addr  (req.ram_addr),
    .wdata (req.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (fire) begin
      s_valid <= 1'b1;
    end else if (s_adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s.mode   <= acc.mode;
      s.addr   <= acc.bus_address;
      s.data   <= acc.data_in;
      s.src    <= req.src;
      s.target <= req.target;
    end
  end

  // A write always records its own data byte as the last data seen.
  always_comb begin
    if (s.mode == MODE_WRITE) begin
      value = s.data;
    end else begin
      case (s.src)
        SRC_EXT: value = s.data;
        SRC_ROM: value = rom_rdata;
        SRC_RAM: value = ram_rdata;
        default: value = 8'h00;
      endcase
    end
  end

  assign ret.bus      = (s.mode == MODE_READ) || (s.mode == MODE_WRITE);
  assign ret.low_page = !s.addr[12];
  assign ret.top_page = (s.addr[12:8] == 5'h1f);
  assign ret.addr     = s.addr;
  assign ret.value    = value;

  cbm_bank_regs u_bank_regs (
    .clk       (clk),
    .rst       (rst),
    .pending   (s_valid),
    .commit    (s_adv),
    .ret       (ret),
    .bank_lock (bank_lock),
    .fwd       (bank_fwd)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv) begin
      out_read_data <= (s.mode == MODE_READ) ? value : 8'h00;
      out_target    <= s.target;
    end
  end

  assign res.valid           = out_valid;
  assign res.read_data       = out_read_data;
  assign res.external_target = out_target;

endmodule
